// ===== rtl/rtis_pkg.sv =====
// Package for the rigid transform inlier scorer: field widths, payload
// structs, configuration register codes and the shared configuration view.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtis_pkg;

  // Field widths fixed by the interface.
  localparam int IDX_W   = 20;
  localparam int CNT_W   = IDX_W + 1;
  localparam int RANK_W  = 8;
  localparam int COORD_W = 32;
  localparam int ERR_W   = 64;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;

  // Transform entries, three rows of three coefficients and a translation.
  localparam int MAT_N = 12;

  // Default depth of the queue between the arithmetic front and the tracker.
  localparam int QUEUE_DEPTH_DEF = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAIR0  = 3'd0,
    REG_PAIR1  = 3'd1,
    REG_PAIR2  = 3'd2,
    REG_PAIR3  = 3'd3,
    REG_PAIR4  = 3'd4,
    REG_PAIR5  = 3'd5,
    REG_THRESH = 3'd6,
    REG_TOPK   = 3'd7
  } cfg_reg_t;

  // One candidate match.
  typedef struct packed {
    logic [IDX_W-1:0]          ref_index;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    logic signed [COORD_W-1:0] ref_z;
    logic signed [COORD_W-1:0] mov_x;
    logic signed [COORD_W-1:0] mov_y;
    logic signed [COORD_W-1:0] mov_z;
    logic                      last_candidate;
    logic                      new_hypothesis;
  } in_item_t;

  // One scored reference point.
  typedef struct packed {
    logic [IDX_W-1:0]  point_index;
    logic [RANK_W-1:0] best_rank;
    logic [ERR_W-1:0]  best_error;
    logic              is_inlier;
    logic [CNT_W-1:0]  inlier_count;
  } out_item_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [MAT_N-1:0][COORD_W-1:0] mat;
    logic [ERR_W-1:0]              thresh_sq;
    logic [RANK_W-1:0]             top_k;
  } cfg_t;

  // Scored candidate handed from the front to the tracker.
  typedef struct packed {
    logic [IDX_W-1:0] ref_index;
    logic [ERR_W-1:0] err;
    logic             below_thresh;
    logic             last_candidate;
    logic             new_hypothesis;
  } q_item_t;

endpackage

`default_nettype wire

// ===== rtl/rtis_front.sv =====
// Front of the scorer: accepts candidate beats, applies the transform and
// forms the squared error in a four-stage pipeline. Depends on rtis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtis_front #(
  parameter int QUEUE_DEPTH = rtis_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rtis_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rtis_pkg::in_item_t in_data,
  input  wire logic               q_pop,
  output logic                    q_push,
  output rtis_pkg::q_item_t       q_data
);

  localparam int CW = rtis_pkg::COORD_W;
  localparam int PW = 2 * CW;          // one exact product
  localparam int AW = PW + 2;          // sum of three products
  localparam int SW = AW - 16;         // floored to Q16.16
  localparam int TW = SW + 1;          // plus translation
  localparam int DW = TW + 1;          // minus reference
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [DW-1:0] D_MAX = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] D_MIN = -DW'(64'sd2147483648);

  typedef struct packed {
    logic [rtis_pkg::IDX_W-1:0] ref_index;
    logic                       last_candidate;
    logic                       new_hypothesis;
  } tag_t;

  logic accept;
  assign accept = in_valid && in_ready;

  // Credit count: beats accepted and not yet taken from the queue.
  logic [FW-1:0] inflight_r, inflight_nxt;
  assign in_ready = (inflight_r < FW'(QUEUE_DEPTH));

  always_comb begin
    inflight_nxt = inflight_r;
    if (accept && !q_pop) begin
      inflight_nxt = inflight_r + FW'(1);
    end else if (!accept && q_pop) begin
      inflight_nxt = inflight_r - FW'(1);
    end
  end

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      inflight_r <= inflight_nxt;
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1: nine coefficient times coordinate products.
  logic signed [CW-1:0] mov [3];
  logic signed [CW-1:0] refc [3];
  logic signed [PW-1:0] prod_nxt [3][3];
  logic signed [PW-1:0] prod_r [3][3];
  logic signed [CW-1:0] ref1_r [3];
  tag_t tag1_r, tag2_r, tag3_r, tag4_r;

  assign mov[0]  = in_data.mov_x;
  assign mov[1]  = in_data.mov_y;
  assign mov[2]  = in_data.mov_z;
  assign refc[0] = in_data.ref_x;
  assign refc[1] = in_data.ref_y;
  assign refc[2] = in_data.ref_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = $signed(cfg.mat[r * 4 + c]) * mov[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= prod_nxt;
      ref1_r <= refc;
      tag1_r <= '{in_data.ref_index, in_data.last_candidate, in_data.new_hypothesis};
    end
  end

  // Stage 2: per axis sum, floor to Q16.16 and add the translation.
  logic signed [AW-1:0] acc [3];
  logic signed [TW-1:0] tr_nxt [3];
  logic signed [TW-1:0] tr_r [3];
  logic signed [CW-1:0] ref2_r [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(prod_r[r][0]) + AW'(prod_r[r][1]) + AW'(prod_r[r][2]);
      tr_nxt[r] = TW'($signed(acc[r][AW-1:16])) + TW'($signed(cfg.mat[r * 4 + 3]));
    end
  end

  always_ff @(posedge clk) begin
    tr_r   <= tr_nxt;
    ref2_r <= ref1_r;
    tag2_r <= tag1_r;
  end

  // Stage 3: difference to the reference, clamp, magnitude.
  logic signed [DW-1:0] dif [3];
  logic signed [DW-1:0] dcl [3];
  logic signed [DW-1:0] dneg [3];
  logic [CW-1:0] mag_nxt [3];
  logic [CW-1:0] mag_r [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dif[r] = DW'(tr_r[r]) - DW'(ref2_r[r]);
      if (dif[r] > D_MAX) begin
        dcl[r] = D_MAX;
      end else if (dif[r] < D_MIN) begin
        dcl[r] = D_MIN;
      end else begin
        dcl[r] = dif[r];
      end
      dneg[r] = -dcl[r];
      mag_nxt[r] = dcl[r][DW-1] ? dneg[r][CW-1:0] : dcl[r][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    tag3_r <= tag2_r;
  end

  // Stage 4: squares.
  logic [PW-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      sq_r[r] <= PW'(mag_r[r]) * PW'(mag_r[r]);
    end
    tag4_r <= tag3_r;
  end

  // Error sum and threshold test go straight into the queue.
  logic [rtis_pkg::ERR_W-1:0] err;
  assign err = sq_r[0] + sq_r[1] + sq_r[2];

  assign q_push = v4_r;
  always_comb begin
    q_data.ref_index      = tag4_r.ref_index;
    q_data.err            = err;
    q_data.below_thresh   = (err < cfg.thresh_sq);
    q_data.last_candidate = tag4_r.last_candidate;
    q_data.new_hypothesis = tag4_r.new_hypothesis;
  end

endmodule

`default_nettype wire

// ===== rtl/rtis_queue.sv =====
// Short queue of scored candidates between the front and the tracker.
// Depends on rtis_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module rtis_queue #(
  parameter int DEPTH = rtis_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rtis_pkg::q_item_t push_data,
  input  wire logic              pop,
  output logic                   not_empty,
  output rtis_pkg::q_item_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtis_pkg::q_item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rtis_back.sv =====
// Back of the scorer: tracks the first minimum per reference point, keeps
// the inlier count and holds the result register. Depends on rtis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtis_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rtis_pkg::cfg_t    cfg,
  input  wire logic              q_valid,
  input  wire rtis_pkg::q_item_t q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rtis_pkg::out_item_t    out_data
);

  localparam int RW = rtis_pkg::RANK_W;
  localparam int EW = rtis_pkg::ERR_W;
  localparam int CW = rtis_pkg::CNT_W;
  localparam logic [RW-1:0] RANK_SAT = '1;
  localparam logic [CW-1:0] CNT_MAX  = {1'b1, {(CW - 1){1'b0}}};

  logic [RW-1:0] rank_r, rank_nxt;
  logic [RW-1:0] min_rank_r, min_rank_nxt;
  logic [EW-1:0] min_err_r, min_err_nxt;
  logic          min_inl_r, min_inl_nxt;
  logic          scored_r, scored_nxt;
  logic [CW-1:0] hit_r, hit_nxt;
  logic          out_valid_r, out_valid_nxt;
  rtis_pkg::out_item_t out_r, out_nxt;

  logic          take;
  logic          cur_scored;
  logic          cur_inl;
  logic [CW-1:0] hit_base;

  // A beat leaves the queue whenever the result register can take a result.
  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Minimum tracking and result forming for the popped beat.
  always_comb begin
    rank_nxt      = rank_r;
    min_rank_nxt  = min_rank_r;
    min_err_nxt   = min_err_r;
    min_inl_nxt   = min_inl_r;
    scored_nxt    = scored_r;
    hit_nxt       = hit_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    take = (rank_r < cfg.top_k) && (!scored_r || (q_data.err < min_err_r));
    hit_base = q_data.new_hypothesis ? '0 : hit_r;

    if (take) begin
      cur_scored = 1'b1;
      cur_inl    = q_data.below_thresh;
    end else begin
      cur_scored = scored_r;
      cur_inl    = scored_r && min_inl_r;
    end

    if (q_pop) begin
      hit_nxt = hit_base;
      if (take) begin
        min_err_nxt  = q_data.err;
        min_rank_nxt = rank_r;
        min_inl_nxt  = q_data.below_thresh;
        scored_nxt   = 1'b1;
      end
      if (rank_r != RANK_SAT) begin
        rank_nxt = rank_r + RW'(1);
      end

      if (q_data.last_candidate) begin
        if (cur_inl && (hit_base < CNT_MAX)) begin
          hit_nxt = hit_base + CW'(1);
        end
        out_nxt.point_index  = q_data.ref_index;
        out_nxt.best_rank    = cur_scored ? min_rank_nxt : '0;
        out_nxt.best_error   = cur_scored ? min_err_nxt : '0;
        out_nxt.is_inlier    = cur_inl;
        out_nxt.inlier_count = (cur_inl && (hit_base < CNT_MAX)) ? hit_base + CW'(1)
                                                                 : hit_base;
        out_valid_nxt = 1'b1;
        // Start the next reference point afresh.
        rank_nxt     = '0;
        min_rank_nxt = '0;
        min_err_nxt  = '1;
        min_inl_nxt  = 1'b0;
        scored_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r      <= '0;
      min_rank_r  <= '0;
      min_err_r   <= '1;
      min_inl_r   <= 1'b0;
      scored_r    <= 1'b0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rank_r      <= rank_nxt;
      min_rank_r  <= min_rank_nxt;
      min_err_r   <= min_err_nxt;
      min_inl_r   <= min_inl_nxt;
      scored_r    <= scored_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/rigid_transform_inlier_scorer_core.sv =====
// Top level of the rigid transform inlier scorer: configuration registers
// and the front, queue and back. Depends on rtis_pkg, rtis_front,
// rtis_queue and rtis_back.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_data   (rtis_pkg::in_item_t)
//   out      out_valid / out_ready  out_data  (rtis_pkg::out_item_t)
//   cfg      cfg_we                 cfg_index, cfg_wdata (64 bits)
//
// One candidate beat is taken every cycle when the result side keeps up; a
// result is offered after its last candidate passes the pipeline stages, the
// queue and the result register. The rate is set by the credit count against
// QUEUE_DEPTH, which covers the four pipeline stages and the queue; one loop
// is the tracker's compare of each error with the running minimum, done combinationally.
// Reset is synchronous; there is no clearing pass.
// When out_ready is low the result register holds, the queue fills and
// in_ready drops once QUEUE_DEPTH beats are in flight.
`timescale 1ns / 1ps
`default_nettype none

module rigid_transform_inlier_scorer_core #(
  parameter int QUEUE_DEPTH = rtis_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rtis_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rtis_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [rtis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rtis_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int CW = rtis_pkg::COORD_W;

  rtis_pkg::cfg_t cfg_r, cfg_nxt;

  // Register writes; each matrix pair fills two transform entries.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (rtis_pkg::cfg_reg_t'(cfg_index))
        rtis_pkg::REG_PAIR0,
        rtis_pkg::REG_PAIR1,
        rtis_pkg::REG_PAIR2,
        rtis_pkg::REG_PAIR3,
        rtis_pkg::REG_PAIR4,
        rtis_pkg::REG_PAIR5: begin
          cfg_nxt.mat[{cfg_index, 1'b0}] = cfg_wdata[CW-1:0];
          cfg_nxt.mat[{cfg_index, 1'b1}] = cfg_wdata[2*CW-1:CW];
        end
        rtis_pkg::REG_THRESH: begin
          cfg_nxt.thresh_sq = cfg_wdata;
        end
        rtis_pkg::REG_TOPK: begin
          cfg_nxt.top_k = cfg_wdata[rtis_pkg::RANK_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mat       <= '0;
      cfg_r.thresh_sq <= '0;
      cfg_r.top_k     <= rtis_pkg::RANK_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front, queue and back.
  logic              q_push;
  logic              q_pop;
  logic              q_not_empty;
  rtis_pkg::q_item_t q_wdata;
  rtis_pkg::q_item_t q_rdata;

  rtis_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_pop    (q_pop),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  rtis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  rtis_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
